// File: src/rslc_pkg.sv
package rslc_pkg;

    // Field widths of the plot and of the configuration registers.
    localparam int IO_W       = 27;
    localparam int R_W        = 30;
    localparam int H_W        = 21;
    localparam int NZ_W       = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 30;

    // Internal widths fixed by the field widths.
    localparam int SUM_W = 2 * IO_W;        // e^2 + n^2
    localparam int RHO_W = SUM_W / 2;       // ground range
    localparam int D_W   = IO_W + 1;        // z - h
    localparam int RD_W  = R_W + 1 + D_W;   // R * (z - h)
    localparam int ZZ_W  = 2 * IO_W;        // z^2
    localparam int HH_W  = 2 * H_W;         // h^2
    localparam int T_W   = RD_W + 2;        // 2R(z - h) + z^2
    localparam int NUM_W = T_W + 1;         // full numerator
    localparam int RH_W  = R_W + 2;         // R + h, signed
    localparam int DEN_W = RHO_W + R_W + 2; // 2 * rho * (R + h)
    localparam int REM_W = DEN_W + 1;       // long division remainder
    localparam int MAG_W = IO_W + 2;        // rounded product magnitude

    localparam int FRACTION_BITS_DEF = 30;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_EARTH_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RADAR_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_ZERO    = 2'd2;

    // Register reset values.
    localparam logic [R_W-1:0]         EARTH_RADIUS_RST = R_W'(637813700);
    localparam logic signed [H_W-1:0]  RADAR_HEIGHT_RST = '0;
    localparam logic [NZ_W-1:0]        NEAR_ZERO_RST    = NZ_W'(1);

    // Height code for a plot without altitude (-1000 m).
    localparam logic signed [IO_W-1:0] NOT_FILLED_CM = IO_W'(-100000);

    // Output saturation limits.
    localparam logic [IO_W-1:0]  IO_MAX  = {1'b0, {(IO_W-1){1'b1}}};
    localparam logic [IO_W-1:0]  IO_MIN  = {1'b1, {(IO_W-1){1'b0}}};
    localparam logic [MAG_W-1:0] NEG_LIM = MAG_W'(1) << (IO_W - 1);
    localparam logic [MAG_W-1:0] POS_LIM = NEG_LIM - MAG_W'(1);

    // Plot data ahead of the ground range square root.
    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [IO_W-1:0]  ae;
        logic [IO_W-1:0]  an;
        logic             se;
        logic             sn;
        logic             near;
    } t_pre;

    // Plot data from the division onward.
    typedef struct packed {
        logic [IO_W-1:0]  ae;
        logic [IO_W-1:0]  an;
        logic             se;
        logic             sn;
        logic [RHO_W-1:0] rho;
        logic             neg;
        logic             zero;
    } t_plot;

endpackage

// File: src/rslc_sqrt_pipe.sv
module rslc_sqrt_pipe #(
    parameter int IN_W  = 54,
    parameter int PAY_W = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [IN_W-1:0]      i_radicand,
    input  logic [PAY_W-1:0]     i_pay,
    output logic                 o_valid,
    output logic [IN_W/2-1:0]    o_root,
    output logic [PAY_W-1:0]     o_pay
);

    localparam int RT_W = IN_W / 2;
    localparam int RM_W = RT_W + 3;

    // One restoring root bit per stage; the last stage keeps no remainder.
    logic [RM_W-1:0]  r_rem   [RT_W-1];
    logic [IN_W-1:0]  r_x     [RT_W-1];
    logic [RT_W-1:0]  r_root  [RT_W];
    logic [PAY_W-1:0] r_pay   [RT_W];
    logic             r_valid [RT_W];

    logic [RM_W-1:0]  w_rem_in   [RT_W];
    logic [IN_W-1:0]  w_x_in     [RT_W];
    logic [RT_W-1:0]  w_root_in  [RT_W];
    logic [PAY_W-1:0] w_pay_in   [RT_W];
    logic             w_valid_in [RT_W];

    for (genvar k = 0; k < RT_W; k++) begin : g_stage
        logic [RM_W-1:0] w_cat;
        logic [RM_W-1:0] w_trial;
        logic            w_ge;
        logic [RM_W-1:0] n_rem;

        // Stage inputs come from the ports or from the stage before.
        if (k == 0) begin : g_first
            assign w_rem_in[k]   = '0;
            assign w_x_in[k]     = i_radicand;
            assign w_root_in[k]  = '0;
            assign w_pay_in[k]   = i_pay;
            assign w_valid_in[k] = i_valid;
        end else begin : g_next
            assign w_rem_in[k]   = r_rem[k-1];
            assign w_x_in[k]     = r_x[k-1];
            assign w_root_in[k]  = r_root[k-1];
            assign w_pay_in[k]   = r_pay[k-1];
            assign w_valid_in[k] = r_valid[k-1];
        end

        // Bring down two radicand bits and try the next root bit.
        assign w_cat   = {w_rem_in[k][RM_W-3:0], w_x_in[k][IN_W-1 -: 2]};
        assign w_trial = {1'b0, w_root_in[k], 2'b01};
        assign w_ge    = w_cat >= w_trial;
        assign n_rem   = w_ge ? (w_cat - w_trial) : w_cat;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= w_valid_in[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[k] <= {w_root_in[k][RT_W-2:0], w_ge};
                r_pay[k]  <= w_pay_in[k];
            end
        end

        if (k < RT_W - 1) begin : g_keep
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= n_rem;
                    r_x[k]   <= {w_x_in[k][IN_W-3:0], 2'b00};
                end
            end
        end
    end

    assign o_valid = r_valid[RT_W-1];
    assign o_root  = r_root[RT_W-1];
    assign o_pay   = r_pay[RT_W-1];

endmodule

// File: src/radar_slant_to_local_cartesian_top.sv
// Converts one radar plot (slant east, north and altitude in centimetres) into local
// Cartesian east, north and up with earth curvature taken into account. The block is a
// fully pipelined datapath: it takes one plot per clock unless o_in_stall is high and gives
// one result per plot, in order. Its bit-per-stage units are the ground range square root
// (27 stages), the sine division (FRACTION_BITS + 2 stages) and the cosine square root
// (FRACTION_BITS + 1 stages). Configuration registers are written through a port that
// is always ready and must only be written while no plot is in flight.
module radar_slant_to_local_cartesian_top #(
    parameter int FRACTION_BITS = rslc_pkg::FRACTION_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic signed [rslc_pkg::IO_W-1:0]       i_east_in,
    input  logic signed [rslc_pkg::IO_W-1:0]       i_north_in,
    input  logic signed [rslc_pkg::IO_W-1:0]       i_height_in,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [rslc_pkg::IO_W-1:0]       o_east_out,
    output logic signed [rslc_pkg::IO_W-1:0]       o_north_out,
    output logic signed [rslc_pkg::IO_W-1:0]       o_up_out,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [rslc_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [rslc_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    import rslc_pkg::*;

    localparam int F      = FRACTION_BITS;
    localparam int QW     = F + 2;               // raw quotient
    localparam int SW     = F + 1;               // sine and cosine
    localparam int SL     = (SW + 1) / 2;        // low half of a split operand
    localparam int SH     = SW - SL;             // high half
    localparam int XW     = 2 * F + 2;           // cosine radicand
    localparam int ACC_W  = IO_W + SW + 1;       // product plus rounding
    localparam int PLOT_W = $bits(t_plot);
    localparam int PRE_W  = $bits(t_pre);
    localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (F - 1);
    localparam logic [XW-1:0]    ONE2 = XW'(1) << (2 * F);

    // Round-to-integer magnitude with sign, saturated to the output range.
    function automatic logic [IO_W-1:0] sat_sign(input logic neg, input logic [MAG_W-1:0] mag);
        logic [IO_W-1:0] res;
        if (neg) begin
            res = (mag > NEG_LIM) ? IO_MIN : IO_W'(~mag + MAG_W'(1));
        end else begin
            res = (mag > POS_LIM) ? IO_MAX : mag[IO_W-1:0];
        end
        return res;
    endfunction

    // Configuration registers.
    logic [R_W-1:0]        r_radius;
    logic signed [H_W-1:0] r_height;
    logic [NZ_W-1:0]       r_near;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= EARTH_RADIUS_RST;
            r_height <= RADAR_HEIGHT_RST;
            r_near   <= NEAR_ZERO_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_EARTH_RADIUS: r_radius <= i_cfg_data[R_W-1:0];
                REG_RADAR_HEIGHT: r_height <= i_cfg_data[H_W-1:0];
                REG_NEAR_ZERO:    r_near   <= i_cfg_data[NZ_W-1:0];
                default:          ;
            endcase
        end
    end

    // Flow control: the whole pipeline moves unless a finished result is blocked
    // behind a stalled output register.
    logic r_m1_valid;
    logic w_out_free;
    logic w_en;

    assign w_out_free = !o_out_valid || !i_out_stall;
    assign w_en       = w_out_free || !r_m1_valid;
    assign o_in_stall = !w_en;

    // Stage 1: take the plot, fill in a missing altitude, form z - h.
    logic                   r1_valid;
    logic signed [IO_W-1:0] r1_e, r1_n, r1_z;
    logic signed [D_W-1:0]  r1_d;
    logic signed [IO_W-1:0] w_z_in;

    assign w_z_in = (i_height_in == NOT_FILLED_CM) ? IO_W'(r_height) : i_height_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_e <= i_east_in;
            r1_n <= i_north_in;
            r1_z <= w_z_in;
            r1_d <= D_W'(w_z_in) - D_W'(r_height);
        end
    end

    // Stage 2: magnitudes and east squared.
    logic                   r2_valid;
    logic [IO_W-1:0]        r2_ae, r2_an;
    logic                   r2_se, r2_sn;
    logic [SUM_W-1:0]       r2_ee;
    logic signed [IO_W-1:0] r2_z;
    logic signed [D_W-1:0]  r2_d;
    logic [IO_W-1:0]        w_ae, w_an;

    assign w_ae = r1_e[IO_W-1] ? (~r1_e + 1'b1) : r1_e;
    assign w_an = r1_n[IO_W-1] ? (~r1_n + 1'b1) : r1_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_ae <= w_ae;
            r2_an <= w_an;
            r2_se <= r1_e[IO_W-1];
            r2_sn <= r1_n[IO_W-1];
            r2_ee <= w_ae * w_ae;
            r2_z  <= r1_z;
            r2_d  <= r1_d;
        end
    end

    // Stage 3: north squared.
    logic                   r3_valid;
    logic [IO_W-1:0]        r3_ae, r3_an;
    logic                   r3_se, r3_sn;
    logic [SUM_W-1:0]       r3_ee, r3_nn;
    logic signed [IO_W-1:0] r3_z;
    logic signed [D_W-1:0]  r3_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (w_en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_ae <= r2_ae;
            r3_an <= r2_an;
            r3_se <= r2_se;
            r3_sn <= r2_sn;
            r3_ee <= r2_ee;
            r3_nn <= r2_an * r2_an;
            r3_z  <= r2_z;
            r3_d  <= r2_d;
        end
    end

    // Stage 4: squared ground range and R * (z - h).
    logic                   r4_valid;
    logic [IO_W-1:0]        r4_ae, r4_an;
    logic                   r4_se, r4_sn;
    logic [SUM_W-1:0]       r4_sum;
    logic signed [RD_W-1:0] r4_rd;
    logic signed [IO_W-1:0] r4_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (w_en) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_ae  <= r3_ae;
            r4_an  <= r3_an;
            r4_se  <= r3_se;
            r4_sn  <= r3_sn;
            r4_sum <= r3_ee + r3_nn;
            r4_rd  <= $signed({1'b0, r_radius}) * r3_d;
            r4_z   <= r3_z;
        end
    end

    // Stage 5: z squared and the short ground range test.
    logic                   r5_valid;
    logic [IO_W-1:0]        r5_ae, r5_an;
    logic                   r5_se, r5_sn, r5_near;
    logic [SUM_W-1:0]       r5_sum;
    logic signed [RD_W-1:0] r5_rd;
    logic signed [ZZ_W-1:0] r5_zz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (w_en) begin
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_ae   <= r4_ae;
            r5_an   <= r4_an;
            r5_se   <= r4_se;
            r5_sn   <= r4_sn;
            r5_sum  <= r4_sum;
            r5_rd   <= r4_rd;
            r5_zz   <= r4_z * r4_z;
            r5_near <= r4_sum < (SUM_W'(r_near) * SUM_W'(r_near));
        end
    end

    // Stage 6: h squared and 2R(z - h) + z^2.
    logic                   r6_valid;
    logic [IO_W-1:0]        r6_ae, r6_an;
    logic                   r6_se, r6_sn, r6_near;
    logic [SUM_W-1:0]       r6_sum;
    logic signed [HH_W-1:0] r6_hh;
    logic signed [T_W-1:0]  r6_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_valid <= 1'b0;
        end else if (w_en) begin
            r6_valid <= r5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_ae   <= r5_ae;
            r6_an   <= r5_an;
            r6_se   <= r5_se;
            r6_sn   <= r5_sn;
            r6_near <= r5_near;
            r6_sum  <= r5_sum;
            r6_hh   <= r_height * r_height;
            r6_t    <= (T_W'(r5_rd) <<< 1) + T_W'(r5_zz);
        end
    end

    // Stage 7: the numerator of the elevation sine.
    logic                    r7_valid;
    logic [IO_W-1:0]         r7_ae, r7_an;
    logic                    r7_se, r7_sn, r7_near;
    logic [SUM_W-1:0]        r7_sum;
    logic signed [NUM_W-1:0] r7_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_valid <= 1'b0;
        end else if (w_en) begin
            r7_valid <= r6_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_ae   <= r6_ae;
            r7_an   <= r6_an;
            r7_se   <= r6_se;
            r7_sn   <= r6_sn;
            r7_near <= r6_near;
            r7_sum  <= r6_sum;
            r7_num  <= NUM_W'(r6_t) - NUM_W'(r6_hh) - NUM_W'($signed({1'b0, r6_sum}));
        end
    end

    // Ground range: rho = floor(sqrt(e^2 + n^2)).
    t_pre             w_pre_in, w_pre;
    logic [PRE_W-1:0] w_pre_out;
    logic             w_s1_valid;
    logic [RHO_W-1:0] w_rho;

    assign w_pre_in = '{num: r7_num, ae: r7_ae, an: r7_an, se: r7_se, sn: r7_sn,
                        near: r7_near};

    rslc_sqrt_pipe #(
        .IN_W  (SUM_W),
        .PAY_W (PRE_W)
    ) u_rho_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (r7_valid),
        .i_radicand (r7_sum),
        .i_pay      (w_pre_in),
        .o_valid    (w_s1_valid),
        .o_root     (w_rho),
        .o_pay      (w_pre_out)
    );

    assign w_pre = w_pre_out;

    // Divider setup: denominator 2 * rho * (R + h), numerator magnitude.
    logic                   r_d0_valid;
    logic [DEN_W-1:0]       r_d0_den;
    logic [NUM_W-2:0]       r_d0_r;
    t_plot                  r_d0_plot;
    logic signed [RH_W-1:0] w_rh;
    logic                   w_rh_pos;
    logic [NUM_W-1:0]       w_num_abs;

    assign w_rh      = $signed({2'b00, r_radius}) + RH_W'(r_height);
    assign w_rh_pos  = !w_rh[RH_W-1] && (w_rh != '0);
    assign w_num_abs = w_pre.num[NUM_W-1] ? (~w_pre.num + 1'b1) : w_pre.num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d0_valid <= 1'b0;
        end else if (w_en) begin
            r_d0_valid <= w_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d0_den       <= {(DEN_W-1)'(w_rho) * (DEN_W-1)'(w_rh[RH_W-2:0]), 1'b0};
            r_d0_r         <= w_num_abs[NUM_W-2:0];
            r_d0_plot.ae   <= w_pre.ae;
            r_d0_plot.an   <= w_pre.an;
            r_d0_plot.se   <= w_pre.se;
            r_d0_plot.sn   <= w_pre.sn;
            r_d0_plot.rho  <= w_rho;
            r_d0_plot.neg  <= w_pre.num[NUM_W-1];
            r_d0_plot.zero <= w_pre.near || (w_rho == '0) || !w_rh_pos;
        end
    end

    // Sine out of range check.
    logic             r_d1_valid;
    logic [REM_W-1:0] r_d1_rem;
    logic [DEN_W-1:0] r_d1_den;
    t_plot            r_d1_plot;
    t_plot            w_d1_plot;

    always_comb begin
        w_d1_plot      = r_d0_plot;
        w_d1_plot.zero = r_d0_plot.zero || (r_d0_r > (NUM_W-1)'(r_d0_den));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1_valid <= 1'b0;
        end else if (w_en) begin
            r_d1_valid <= r_d0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d1_rem  <= REM_W'(r_d0_r[DEN_W-1:0]);
            r_d1_den  <= r_d0_den;
            r_d1_plot <= w_d1_plot;
        end
    end

    // Restoring division, one quotient bit per stage, integer bit first.
    logic [REM_W-1:0] r_dv_rem   [QW-1];
    logic [DEN_W-1:0] r_dv_den   [QW-1];
    logic [QW-1:0]    r_dv_q     [QW];
    t_plot            r_dv_plot  [QW];
    logic             r_dv_valid [QW];

    logic [REM_W-1:0] w_dv_rem_in   [QW];
    logic [DEN_W-1:0] w_dv_den_in   [QW];
    logic [QW-1:0]    w_dv_q_in     [QW];
    t_plot            w_dv_plot_in  [QW];
    logic             w_dv_valid_in [QW];

    for (genvar k = 0; k < QW; k++) begin : g_div
        logic             w_ge;
        logic [REM_W-1:0] w_sub;

        if (k == 0) begin : g_first
            assign w_dv_rem_in[k]   = r_d1_rem;
            assign w_dv_den_in[k]   = r_d1_den;
            assign w_dv_q_in[k]     = '0;
            assign w_dv_plot_in[k]  = r_d1_plot;
            assign w_dv_valid_in[k] = r_d1_valid;
        end else begin : g_next
            assign w_dv_rem_in[k]   = r_dv_rem[k-1];
            assign w_dv_den_in[k]   = r_dv_den[k-1];
            assign w_dv_q_in[k]     = r_dv_q[k-1];
            assign w_dv_plot_in[k]  = r_dv_plot[k-1];
            assign w_dv_valid_in[k] = r_dv_valid[k-1];
        end

        assign w_ge  = w_dv_rem_in[k] >= REM_W'(w_dv_den_in[k]);
        assign w_sub = w_ge ? (w_dv_rem_in[k] - REM_W'(w_dv_den_in[k])) : w_dv_rem_in[k];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_valid[k] <= 1'b0;
            end else if (w_en) begin
                r_dv_valid[k] <= w_dv_valid_in[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv_q[k]    <= {w_dv_q_in[k][QW-2:0], w_ge};
                r_dv_plot[k] <= w_dv_plot_in[k];
            end
        end

        if (k < QW - 1) begin : g_keep
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_dv_rem[k] <= {w_sub[REM_W-2:0], 1'b0};
                    r_dv_den[k] <= w_dv_den_in[k];
                end
            end
        end
    end

    // Round the quotient half up to the sine s.
    logic          r_r0_valid;
    logic [SW-1:0] r_r0_s;
    t_plot         r_r0_plot;
    logic [QW-1:0] w_q_rnd;

    assign w_q_rnd = r_dv_q[QW-1] + QW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r0_valid <= 1'b0;
        end else if (w_en) begin
            r_r0_valid <= r_dv_valid[QW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_r0_s    <= w_q_rnd[QW-1:1];
            r_r0_plot <= r_dv_plot[QW-1];
        end
    end

    // s squared as three partial products.
    logic             r_c0_valid;
    logic [2*SH-1:0]  r_c0_hh;
    logic [SH+SL-1:0] r_c0_hl;
    logic [2*SL-1:0]  r_c0_ll;
    logic [SW-1:0]    r_c0_s;
    t_plot            r_c0_plot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c0_valid <= 1'b0;
        end else if (w_en) begin
            r_c0_valid <= r_r0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c0_hh   <= r_r0_s[SW-1:SL] * r_r0_s[SW-1:SL];
            r_c0_hl   <= r_r0_s[SW-1:SL] * r_r0_s[SL-1:0];
            r_c0_ll   <= r_r0_s[SL-1:0] * r_r0_s[SL-1:0];
            r_c0_s    <= r_r0_s;
            r_c0_plot <= r_r0_plot;
        end
    end

    // Cosine radicand 2^(2F) - s^2.
    logic          r_c1_valid;
    logic [XW-1:0] r_c1_x;
    logic [SW-1:0] r_c1_s;
    t_plot         r_c1_plot;
    logic [XW-1:0] w_sq;

    assign w_sq = (XW'(r_c0_hh) << (2 * SL)) + (XW'(r_c0_hl) << (SL + 1)) + XW'(r_c0_ll);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1_valid <= 1'b0;
        end else if (w_en) begin
            r_c1_valid <= r_c0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c1_x    <= ONE2 - w_sq;
            r_c1_s    <= r_c0_s;
            r_c1_plot <= r_c0_plot;
        end
    end

    // Cosine c = floor(sqrt(2^(2F) - s^2)).
    logic                 w_s2_valid;
    logic [SW-1:0]        w_c;
    logic [SW+PLOT_W-1:0] w_s2_pay;
    logic [SW-1:0]        w_s2_s;
    t_plot                w_s2_plot;

    rslc_sqrt_pipe #(
        .IN_W  (XW),
        .PAY_W (SW + PLOT_W)
    ) u_cos_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (r_c1_valid),
        .i_radicand (r_c1_x),
        .i_pay      ({r_c1_s, r_c1_plot}),
        .o_valid    (w_s2_valid),
        .o_root     (w_c),
        .o_pay      (w_s2_pay)
    );

    assign w_s2_s    = w_s2_pay[SW+PLOT_W-1:PLOT_W];
    assign w_s2_plot = w_s2_pay[PLOT_W-1:0];

    // Output products e*c, n*c and rho*s, each as two partial products.
    logic               r_m0_valid;
    logic [IO_W+SH-1:0] r_m0_ehi, r_m0_nhi, r_m0_uhi;
    logic [IO_W+SL-1:0] r_m0_elo, r_m0_nlo, r_m0_ulo;
    t_plot              r_m0_plot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m0_valid <= 1'b0;
        end else if (w_en) begin
            r_m0_valid <= w_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m0_ehi  <= w_s2_plot.ae * w_c[SW-1:SL];
            r_m0_elo  <= w_s2_plot.ae * w_c[SL-1:0];
            r_m0_nhi  <= w_s2_plot.an * w_c[SW-1:SL];
            r_m0_nlo  <= w_s2_plot.an * w_c[SL-1:0];
            r_m0_uhi  <= w_s2_plot.rho * w_s2_s[SW-1:SL];
            r_m0_ulo  <= w_s2_plot.rho * w_s2_s[SL-1:0];
            r_m0_plot <= w_s2_plot;
        end
    end

    // Round, saturate, apply signs, and bypass when the elevation is taken as zero.
    logic [IO_W-1:0]  r_m1_e, r_m1_n, r_m1_u;
    logic [ACC_W-1:0] w_e_acc, w_n_acc, w_u_acc;
    logic [IO_W-1:0]  w_e_flat, w_n_flat;

    assign w_e_acc  = (ACC_W'(r_m0_ehi) << SL) + ACC_W'(r_m0_elo) + HALF;
    assign w_n_acc  = (ACC_W'(r_m0_nhi) << SL) + ACC_W'(r_m0_nlo) + HALF;
    assign w_u_acc  = (ACC_W'(r_m0_uhi) << SL) + ACC_W'(r_m0_ulo) + HALF;
    assign w_e_flat = r_m0_plot.se ? (~r_m0_plot.ae + 1'b1) : r_m0_plot.ae;
    assign w_n_flat = r_m0_plot.sn ? (~r_m0_plot.an + 1'b1) : r_m0_plot.an;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_valid <= 1'b0;
        end else if (w_en) begin
            r_m1_valid <= r_m0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_m0_plot.zero) begin
                r_m1_e <= w_e_flat;
                r_m1_n <= w_n_flat;
                r_m1_u <= '0;
            end else begin
                r_m1_e <= sat_sign(r_m0_plot.se, w_e_acc[ACC_W-1:F]);
                r_m1_n <= sat_sign(r_m0_plot.sn, w_n_acc[ACC_W-1:F]);
                r_m1_u <= sat_sign(r_m0_plot.neg, w_u_acc[ACC_W-1:F]);
            end
        end
    end

    // Output register; a transaction completes when valid is high and stall is low.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_out_free) begin
            o_out_valid <= r_m1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            o_east_out  <= r_m1_e;
            o_north_out <= r_m1_n;
            o_up_out    <= r_m1_u;
        end
    end

endmodule

// File: dv/rslc_plot_checker.sv
`timescale 1ns / 1ps

// Watches the plot, result and register channels of the converter, works out the
// local Cartesian coordinates of every accepted plot and compares them in order.
module rslc_plot_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic signed [rslc_pkg::IO_W-1:0]    i_east_in,
    input  logic signed [rslc_pkg::IO_W-1:0]    i_north_in,
    input  logic signed [rslc_pkg::IO_W-1:0]    i_height_in,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic signed [rslc_pkg::IO_W-1:0]    i_east_out,
    input  logic signed [rslc_pkg::IO_W-1:0]    i_north_out,
    input  logic signed [rslc_pkg::IO_W-1:0]    i_up_out,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [rslc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rslc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import rslc_pkg::*;

    localparam int FB = FRACTION_BITS_DEF;
    localparam longint ONE_Q = longint'(1) <<< FB;
    localparam longint OUT_MAX = (longint'(1) <<< (IO_W - 1)) - 1;
    localparam longint OUT_MIN = -(longint'(1) <<< (IO_W - 1));

    typedef struct {
        logic signed [IO_W-1:0] east;
        logic signed [IO_W-1:0] north;
        logic signed [IO_W-1:0] up;
    } t_local_xyz;

    t_local_xyz xyz_expected[$];
    longint     radius_cm;
    longint     site_height_cm;
    longint     near_range_cm;

    // Rounds mag * frac / 2^FB half away from zero.
    function automatic longint round_scaled(longint mag, longint frac);
        return (mag * frac + (longint'(1) <<< (FB - 1))) >>> FB;
    endfunction

    // Applies a sign to a magnitude and clamps it to the output range.
    function automatic logic signed [IO_W-1:0] signed_clamp(bit neg, longint mag);
        longint v;
        v = neg ? -mag : mag;
        if (v > OUT_MAX) v = OUT_MAX;
        if (v < OUT_MIN) v = OUT_MIN;
        return v[IO_W-1:0];
    endfunction

    // Local east, north and up of one plot with the current site settings.
    function automatic t_local_xyz plot_to_local(logic signed [IO_W-1:0] e_in,
                                                 logic signed [IO_W-1:0] n_in,
                                                 logic signed [IO_W-1:0] z_in);
        t_local_xyz res;
        longint e, n, z, rh, ae, an, sq_sum, rho, t, num, den, r, q, ip, x, c;
        bit neg;
        bit ok;
        e = e_in;
        n = n_in;
        z = z_in;
        rh = radius_cm + site_height_cm;
        ae = e < 0 ? -e : e;
        an = n < 0 ? -n : n;
        sq_sum = ae * ae + an * an;
        rho = 0;
        for (int b = 27; b >= 0; b--) begin
            t = rho | (longint'(1) <<< b);
            if (t * t <= sq_sum) rho = t;
        end
        res.east = e_in;
        res.north = n_in;
        res.up = '0;
        // A missing altitude takes the antenna altitude.
        if (z_in == NOT_FILLED_CM) z = site_height_cm;
        if (sq_sum >= near_range_cm * near_range_cm && rho != 0 && rh > 0) begin
            num = 2 * radius_cm * (z - site_height_cm) + z * z
                  - site_height_cm * site_height_cm - sq_sum;
            den = 2 * rho * rh;
            neg = num < 0;
            r = neg ? -num : num;
            ok = 1'b1;
            ip = 0;
            q = 0;
            if (r > den) begin
                ok = 1'b0;
            end else if (r == den) begin
                ip = 1;
                r = 0;
            end
            // Sine of elevation: long division, one extra bit, then rounding.
            if (ok) begin
                for (int i = 0; i < FB + 1; i++) begin
                    r = r <<< 1;
                    q = q <<< 1;
                    if (r >= den) begin
                        r = r - den;
                        q = q | 1;
                    end
                end
                q = q | (ip <<< (FB + 1));
                q = (q + 1) >>> 1;
                x = (ONE_Q - q) * (ONE_Q + q);
                c = 0;
                for (int b = FB; b >= 0; b--) begin
                    t = c | (longint'(1) <<< b);
                    if (t * t <= x) c = t;
                end
                res.east = signed_clamp(e < 0, round_scaled(ae, c));
                res.north = signed_clamp(n < 0, round_scaled(an, c));
                res.up = signed_clamp(neg, round_scaled(rho, q));
            end
        end
        return res;
    endfunction

    assign o_pending = xyz_expected.size();

    // Track registers, predict accepted plots and compare accepted results.
    always @(posedge i_clk) begin
        t_local_xyz exp_xyz;
        int         mism;
        mism = 0;
        if (!i_rst_n) begin
            radius_cm <= EARTH_RADIUS_RST;
            site_height_cm <= RADAR_HEIGHT_RST;
            near_range_cm <= NEAR_ZERO_RST;
            o_fail_count <= 0;
            xyz_expected.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_EARTH_RADIUS: radius_cm <= i_cfg_data[R_W-1:0];
                    REG_RADAR_HEIGHT: site_height_cm <= $signed(i_cfg_data[H_W-1:0]);
                    REG_NEAR_ZERO: near_range_cm <= i_cfg_data[NZ_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                xyz_expected.push_back(plot_to_local(i_east_in, i_north_in, i_height_in));
            if (i_out_valid && !i_out_stall) begin
                if (xyz_expected.size() == 0) begin
                    $error("result transaction with no plot outstanding");
                    mism = mism + 1;
                end else begin
                    exp_xyz = xyz_expected.pop_front();
                    if (exp_xyz.east !== i_east_out) begin
                        $error("east_out: expected %0d, actual %0d", exp_xyz.east, i_east_out);
                        mism = mism + 1;
                    end
                    if (exp_xyz.north !== i_north_out) begin
                        $error("north_out: expected %0d, actual %0d",
                               exp_xyz.north, i_north_out);
                        mism = mism + 1;
                    end
                    if (exp_xyz.up !== i_up_out) begin
                        $error("up_out: expected %0d, actual %0d", exp_xyz.up, i_up_out);
                        mism = mism + 1;
                    end
                end
            end
            o_fail_count <= o_fail_count + mism;
        end
    end

endmodule

// File: dv/radar_slant_to_local_cartesian_top_tb.sv
`timescale 1ns / 1ps

module radar_slant_to_local_cartesian_top_tb;
    import rslc_pkg::*;

    localparam int LATENCY = 2 * FRACTION_BITS_DEF + 45;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    logic signed [IO_W-1:0]    i_east_in = '0;
    logic signed [IO_W-1:0]    i_north_in = '0;
    logic signed [IO_W-1:0]    i_height_in = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic signed [IO_W-1:0]    o_east_out;
    logic signed [IO_W-1:0]    o_north_out;
    logic signed [IO_W-1:0]    o_up_out;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]     i_cfg_data = '0;

    int fail_count;
    int plots_pending;
    int send_idle_pct = 0;
    int out_stall_pct = 0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;
    longint cycle_count = 0;

    always #2 i_clk = ~i_clk;

    radar_slant_to_local_cartesian_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_east_in   (i_east_in),
        .i_north_in  (i_north_in),
        .i_height_in (i_height_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_east_out  (o_east_out),
        .o_north_out (o_north_out),
        .o_up_out    (o_up_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    rslc_plot_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_east_in    (i_east_in),
        .i_north_in   (i_north_in),
        .i_height_in  (i_height_in),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_east_out   (o_east_out),
        .i_north_out  (o_north_out),
        .i_up_out     (o_up_out),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (plots_pending)
    );

    // Receiver: random stalls, plus one long hold-off counted here.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Offers one plot, with random gaps ahead of it, and waits for the transaction.
    task automatic send_plot(logic signed [IO_W-1:0] e, logic signed [IO_W-1:0] n,
                             logic signed [IO_W-1:0] z);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_east_in <= e;
        i_north_in <= n;
        i_height_in <= z;
        do @(negedge i_clk); while (o_in_stall);
        @(posedge i_clk);
    endtask

    // Stops offering and waits until every result has come, then idles before returning.
    task automatic drain_plots();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (plots_pending != 0);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    // Offers one register write and waits for the transaction; valid stays high.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(negedge i_clk); while (!o_cfg_ready);
        @(posedge i_clk);
    endtask

    task automatic set_site(longint radius, longint height, longint near_range);
        write_reg(REG_EARTH_RADIUS, CFG_DATA_W'(radius));
        write_reg(REG_RADAR_HEIGHT, CFG_DATA_W'(height));
        write_reg(REG_NEAR_ZERO, CFG_DATA_W'(near_range));
        i_cfg_valid <= 1'b0;
    endtask

    // Random plot drawn from several shapes of traffic.
    task automatic send_random_plot();
        logic signed [IO_W-1:0] e, n, z;
        int shape;
        shape = $urandom_range(5);
        e = IO_W'($urandom);
        n = IO_W'($urandom);
        z = IO_W'($urandom);
        case (shape)
            1: begin
                e = IO_W'(int'($urandom_range(8191)) - 4096);
                n = IO_W'(int'($urandom_range(8191)) - 4096);
                z = IO_W'(int'($urandom_range(32767)) - 16384);
            end
            2, 3: begin
                e = IO_W'(int'($urandom_range(33554431)) - 16777216);
                n = IO_W'(int'($urandom_range(33554431)) - 16777216);
                z = IO_W'($urandom_range(1500000));
            end
            4: begin
                e = IO_W'(int'($urandom_range(33554431)) - 16777216);
                z = NOT_FILLED_CM;
            end
            5: begin
                e = IO_W'(int'($urandom_range(2000)) - 1000);
                n = IO_W'(int'($urandom_range(2000)) - 1000);
            end
            default: ;
        endcase
        send_plot(e, n, z);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed plots at the reset settings.
        send_plot('0, '0, '0);
        send_plot('0, '0, NOT_FILLED_CM);
        send_plot(IO_MAX, IO_MAX, IO_MAX);
        send_plot(IO_MIN, IO_MIN, IO_MIN);
        send_plot(IO_MAX, IO_MIN, '0);
        send_plot(IO_MIN, IO_MAX, NOT_FILLED_CM);
        send_plot(IO_W'(1), '0, '0);
        send_plot('0, IO_W'(-1), IO_W'(500));
        send_plot(IO_W'(100000), IO_W'(-200000), IO_W'(1000000));
        send_plot(IO_W'(100000), IO_W'(-200000), NOT_FILLED_CM);
        send_plot(IO_W'(10), IO_W'(10), IO_MAX);
        send_plot(IO_W'(10), IO_W'(-10), IO_MIN);
        send_plot(IO_W'(-5000000), IO_W'(3000000), IO_W'(5000000));
        send_plot(IO_MAX, IO_MAX, IO_W'(60000000));
        send_plot(IO_MIN, IO_MIN, IO_W'(-60000000));
        send_plot(IO_W'(20000000), IO_W'(20000000), IO_W'(40000000));
        drain_plots();

        // Phases over several site settings, the range extremes among them.
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: set_site(637813700, 0, 1);
                1: set_site(600000000, -50000, 0);
                2: set_site(700000000, 1000000, 1000);
                3: set_site($urandom_range(700000000, 600000000),
                            longint'($urandom_range(1050000)) - 50000,
                            $urandom_range(1000));
                default: set_site(637813700, 1000000, 0);
            endcase
            send_plot('0, '0, '0);
            send_plot(IO_W'(999), '0, IO_W'(1000));
            send_plot(IO_W'(-3), IO_W'(4), NOT_FILLED_CM);
            if (phase == 2) hold_req <= 1'b1;
            for (int k = 0; k < 100; k++) begin
                case ((k / 25 + phase) % 4)
                    0: begin send_idle_pct = 0;  out_stall_pct = 0;  end
                    1: begin send_idle_pct = 54; out_stall_pct = 0;  end
                    2: begin send_idle_pct = 0;  out_stall_pct = 54; end
                    default: begin send_idle_pct = 7; out_stall_pct = 7; end
                endcase
                // Sender pause with nothing in flight, once.
                if (phase == 1 && k == 50) begin
                    i_in_valid <= 1'b0;
                    do @(negedge i_clk); while (plots_pending != 0);
                    @(posedge i_clk);
                end
                send_random_plot();
            end
            send_idle_pct = 0;
            out_stall_pct = 0;
            drain_plots();
        end

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
src/rslc_pkg.sv
src/rslc_sqrt_pipe.sv
src/radar_slant_to_local_cartesian_top.sv
dv/rslc_plot_checker.sv
dv/radar_slant_to_local_cartesian_top_tb.sv
